@@ hw/rtl/gdec_pkg.sv @@
// gdec_pkg: shared types, constants and utf-8 helper functions of the decoder
`default_nettype none

package gdec_pkg;

	// most output bytes one input item may cause
	localparam int unsigned MAX_OUT = 5;

	// one group of bytes handed from the front to the back
	typedef struct packed {
		logic [3:0][7:0] data;  // bytes, first in data[0]
		logic [2:0]      len;   // 1 to 4
		logic            last;  // string ends with this group
	} grp_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// one parsed code point
	typedef struct packed {
		logic [20:0] cp;
		logic [2:0]  adv;  // bytes consumed
	} parse_t;

	// output bytes of one code point
	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;  // 1 to 4
	} enc_t;

	// length of the sequence a byte opens, 1 when it stands alone
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd1;
		if (b[7:5] == 3'b110) begin
			n = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			n = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			n = 3'd4;
		end
		return n;
	endfunction

	// parse one code point at pos, bounded by len
	function automatic parse_t parse_cp(input logic [3:0][7:0] data, input logic [1:0] pos,
			input logic [2:0] len);
		logic [7:0] lead;
		logic [7:0] c1;
		logic [7:0] c2;
		logic [7:0] c3;
		logic [2:0] rem;
		logic [2:0] n;
		parse_t     r;
		lead  = data[pos];
		c1    = data[pos + 2'd1];
		c2    = data[pos + 2'd2];
		c3    = data[pos + 2'd3];
		rem   = len - {1'b0, pos};
		n     = seq_len(lead);
		r.cp  = {13'd0, lead};
		r.adv = 3'd1;
		if (n == 3'd2 && rem >= 3'd2) begin
			r.cp  = {10'd0, lead[4:0], c1[5:0]};
			r.adv = 3'd2;
		end else if (n == 3'd3 && rem >= 3'd3) begin
			r.cp  = {5'd0, lead[3:0], c1[5:0], c2[5:0]};
			r.adv = 3'd3;
		end else if (n == 3'd4 && rem >= 3'd4) begin
			r.cp  = {lead[2:0], c1[5:0], c2[5:0], c3[5:0]};
			r.adv = 3'd4;
		end
		return r;
	endfunction

	// map a code point back to its byte, or re-encode it as utf-8
	function automatic enc_t encode_cp(input logic [20:0] cp);
		logic [6:0] e;
		enc_t       r;
		e   = cp[6:0];
		r.b = '0;
		r.n = 3'd1;
		if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
				(cp >= 21'd174 && cp <= 21'd255)) begin
			r.b[0] = cp[7:0];
		end else if (cp >= 21'd256 && cp <= 21'd323) begin
			// shifted bytes: controls and space, 127..160, soft hyphen
			if (e < 7'd33) begin
				r.b[0] = {1'b0, e};
			end else if (e < 7'd67) begin
				r.b[0] = {1'b0, e} + 8'd94;
			end else begin
				r.b[0] = 8'd173;
			end
		end else if (cp < 21'h80) begin
			r.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			r.n    = 3'd2;
			r.b[0] = 8'hC0 | {3'd0, cp[10:6]};
			r.b[1] = 8'h80 | {2'd0, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.n    = 3'd3;
			r.b[0] = 8'hE0 | {4'd0, cp[15:12]};
			r.b[1] = 8'h80 | {2'd0, cp[11:6]};
			r.b[2] = 8'h80 | {2'd0, cp[5:0]};
		end else begin
			r.n    = 3'd4;
			r.b[0] = 8'hF0 | {5'd0, cp[20:18]};
			r.b[1] = 8'h80 | {2'd0, cp[17:12]};
			r.b[2] = 8'h80 | {2'd0, cp[11:6]};
			r.b[3] = 8'h80 | {2'd0, cp[5:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gdec_in_if.sv @@
// gdec_in_if: input byte channel with valid/ready handshake
`default_nettype none

interface gdec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gdec_out_if.sv @@
// gdec_out_if: decoded byte channel with valid/ready handshake
`default_nettype none

interface gdec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gdec_front.sv @@
// gdec_front: accepts bytes, holds open sequences and forms decode groups
`default_nettype none

module gdec_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	gdec_in_if.sink             text,
	input  gdec_pkg::q_stat_t   qstat,
	output logic                push,
	output gdec_pkg::grp_t      push_grp
);

	logic [7:0] held_q [0:2];
	logic [1:0] cnt_q;
	logic [2:0] need_q;

	logic       accept;
	logic [2:0] len;
	logic [2:0] need;
	logic       hold;

	// classify the incoming byte against the open sequence
	assign text.ready = !qstat.full;
	assign accept     = text.valid && text.ready;
	assign len        = {1'b0, cnt_q} + 3'd1;
	assign need       = (cnt_q != 2'd0) ? need_q : gdec_pkg::seq_len(text.in_byte);
	assign hold       = (len < need) && !text.in_last;
	assign push       = accept && !hold;

	// group is the held bytes followed by the new one
	always_comb begin
		push_grp.data[0] = (cnt_q == 2'd0) ? text.in_byte : held_q[0];
		push_grp.data[1] = (cnt_q > 2'd1) ? held_q[1] :
			((cnt_q == 2'd1) ? text.in_byte : 8'h00);
		push_grp.data[2] = (cnt_q > 2'd2) ? held_q[2] :
			((cnt_q == 2'd2) ? text.in_byte : 8'h00);
		push_grp.data[3] = (cnt_q == 2'd3) ? text.in_byte : 8'h00;
		push_grp.len     = len;
		push_grp.last    = text.in_last;
	end

	// open sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q[0] <= 8'h00;
			held_q[1] <= 8'h00;
			held_q[2] <= 8'h00;
			cnt_q     <= 2'd0;
			need_q    <= 3'd0;
		end else if (accept) begin
			if (hold) begin
				held_q[cnt_q] <= text.in_byte;
				cnt_q         <= len[1:0];
				need_q        <= need;
			end else begin
				cnt_q  <= 2'd0;
				need_q <= 3'd0;
			end
		end
	end

	// an open sequence always still lacks bytes
	a_open_short: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd0 |-> need_q > {1'b0, cnt_q})
		else $error("open sequence already complete");

endmodule

`default_nettype wire

@@ hw/rtl/gdec_queue.sv @@
// gdec_queue: short fifo of decode groups between front and back
`default_nettype none

module gdec_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  gdec_pkg::grp_t     push_grp,
	input  wire logic          pop,
	output gdec_pkg::grp_t     head,
	output gdec_pkg::q_stat_t  qstat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	gdec_pkg::grp_t mem_q [0:DEPTH-1];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ hw/rtl/gdec_back.sv @@
// gdec_back: parses queued groups to code points, one byte/cycle unless stalled
`default_nettype none

module gdec_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  gdec_pkg::grp_t     head,
	input  gdec_pkg::q_stat_t  qstat,
	output logic               pop,
	gdec_out_if.source         decoded
);

	logic [1:0] pos_q;   // byte position of current code point
	logic [1:0] idx_q;   // output byte within current code point
	logic [2:0] ocnt_q;  // bytes emitted for current group
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	gdec_pkg::parse_t pr;
	gdec_pkg::enc_t   en;
	logic             step;
	logic             cp_done;
	logic [2:0]       next_pos;
	logic             grp_done;

	// decode the code point at the current position
	always_comb begin
		pr       = gdec_pkg::parse_cp(head.data, pos_q, head.len);
		en       = gdec_pkg::encode_cp(pr.cp);
		step     = !qstat.empty && (!out_valid_q || decoded.ready);
		cp_done  = ({1'b0, idx_q} == (en.n - 3'd1));
		next_pos = {1'b0, pos_q} + pr.adv;
		grp_done = (cp_done && next_pos == head.len) ||
			(ocnt_q == 3'(gdec_pkg::MAX_OUT - 1));
		pop      = step && grp_done;
	end

	// walk position, byte index and emitted count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 2'd0;
			idx_q  <= 2'd0;
			ocnt_q <= 3'd0;
		end else if (step) begin
			if (grp_done) begin
				pos_q  <= 2'd0;
				idx_q  <= 2'd0;
				ocnt_q <= 3'd0;
			end else if (cp_done) begin
				pos_q  <= next_pos[1:0];
				idx_q  <= 2'd0;
				ocnt_q <= ocnt_q + 3'd1;
			end else begin
				idx_q  <= idx_q + 2'd1;
				ocnt_q <= ocnt_q + 3'd1;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (decoded.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= en.b[idx_q];
			out_last_q <= head.last && grp_done;
		end
	end

	assign decoded.valid    = out_valid_q;
	assign decoded.out_byte = out_byte_q;
	assign decoded.out_last = out_last_q;

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q < 3'(gdec_pkg::MAX_OUT))
		else $error("group emitted too many bytes");

	a_pos_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.empty |-> {1'b0, pos_q} < head.len)
		else $error("parse position past group end");

	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (pos_q == 2'd0 && idx_q == 2'd0 && ocnt_q == 3'd0))
		else $error("walk state not cleared after group");

endmodule

`default_nettype wire

@@ hw/rtl/gpt2_byte_level_utf8_decoder_core.sv @@
// gpt2_byte_level_utf8_decoder_core: top level of the byte-level utf-8 decoder
//
//   channel   dir   handshake      payload
//   text      in    valid/ready    in_byte[7:0], in_last
//   decoded   out   valid/ready    out_byte[7:0], out_last
//
// one input byte accepted per cycle while the group queue has room
// each completed group yields 1 to 5 output bytes, one per cycle from the back end
// while decoded.ready holds; a group's first byte goes via queue and output register
// reset clears the open sequence, queue pointers and output valid
// an output stall fills the queue of QUEUE_DEPTH groups, then text.ready drops
`default_nettype none

module gpt2_byte_level_utf8_decoder_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	gdec_in_if.sink   text,
	gdec_out_if.source decoded
);

	logic              push;
	logic              pop;
	gdec_pkg::grp_t    push_grp;
	gdec_pkg::grp_t    head;
	gdec_pkg::q_stat_t qstat;

	// front: hold open sequences, form groups
	gdec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.qstat    (qstat),
		.push     (push),
		.push_grp (push_grp)
	);

	// group queue
	gdec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// back: parse, map and emit bytes
	gdec_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.decoded (decoded)
	);

endmodule

`default_nettype wire

@@ tb/sv/gpt2_byte_level_utf8_decoder_core_tb.sv @@
// self-checking testbench of the byte-level utf-8 decoder with its own byte-map predictor
`default_nettype none

module gpt2_byte_level_utf8_decoder_core_tb;

	// one decoded output item
	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} dec_item_t;

	// output bytes of one code point
	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} cp_bytes_t;

	// one directed stimulus row, want is checked only where chk is set
	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       chk;
		logic [7:0] want;
	} dir_row_t;

	localparam int unsigned RANDOM_ITEMS = 195;
	localparam int unsigned HOLD_CYCLES  = 150;
	localparam int unsigned BURST_ITEMS  = 40;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RUN_LIMIT    = 2000000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	gdec_in_if  text_if ();
	gdec_out_if dec_if ();

	gpt2_byte_level_utf8_decoder_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_if),
		.decoded (dec_if)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: bytes of the open sequence and its length
	logic [7:0]  held [3];
	int unsigned held_cnt  = 0;
	int unsigned open_need = 0;

	dec_item_t   exp_q [$];
	int unsigned errors      = 0;
	int unsigned in_count    = 0;
	int unsigned out_count   = 0;
	int unsigned str_count   = 0;
	int unsigned flush_count = 0;
	int unsigned stall_count = 0;
	int unsigned send_quiet  = 0;
	int unsigned recv_quiet  = 0;
	int unsigned burst_left  = 0;
	bit          hold_req    = 1'b0;

	// directed rows: plain bytes, byte-map ends, overlong, flushes, lead on last
	dir_row_t dir_rows [0:24] = '{
		'{8'h41, 1'b0, 1'b1, 8'h41},
		'{8'h00, 1'b0, 1'b1, 8'h00},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'h80, 1'b0, 1'b0, 8'h00},
		'{8'hC4, 1'b0, 1'b0, 8'h00},
		'{8'h80, 1'b0, 1'b1, 8'h00},
		'{8'hC5, 1'b0, 1'b0, 8'h00},
		'{8'h83, 1'b0, 1'b1, 8'hAD},
		'{8'hE2, 1'b0, 1'b0, 8'h00},
		'{8'h82, 1'b0, 1'b0, 8'h00},
		'{8'hAC, 1'b0, 1'b0, 8'h00},
		'{8'hF0, 1'b0, 1'b0, 8'h00},
		'{8'h9F, 1'b0, 1'b0, 8'h00},
		'{8'h98, 1'b0, 1'b0, 8'h00},
		'{8'h80, 1'b0, 1'b0, 8'h00},
		'{8'hC0, 1'b0, 1'b0, 8'h00},
		'{8'h80, 1'b0, 1'b0, 8'h00},
		'{8'hF0, 1'b0, 1'b0, 8'h00},
		'{8'h80, 1'b0, 1'b0, 8'h00},
		'{8'h80, 1'b1, 1'b0, 8'h00},
		'{8'hE2, 1'b1, 1'b1, 8'hE2},
		'{8'hF0, 1'b0, 1'b0, 8'h00},
		'{8'hC3, 1'b0, 1'b0, 8'h00},
		'{8'hA9, 1'b1, 1'b0, 8'h00},
		'{8'h7F, 1'b1, 1'b1, 8'h7F}
	};

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// length of the sequence a lead opens, 1 for a byte that stands alone
	function automatic int unsigned lead_len(input logic [7:0] b);
		casez (b)
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 1;
		endcase
	endfunction

	// gpt-2 byte map, else utf-8 re-encoding
	function automatic cp_bytes_t map_cp(input logic [20:0] c);
		cp_bytes_t  r;
		logic [7:0] e;
		r.b = '0;
		r.n = 3'd1;
		e   = c[7:0];
		if ((c >= 21'd33 && c <= 21'd126) || (c >= 21'd161 && c <= 21'd172) ||
				(c >= 21'd174 && c <= 21'd255)) begin
			r.b[0] = c[7:0];
		end else if (c >= 21'd256 && c <= 21'd323) begin
			// 256 + e, e counted over the bytes that are not printable
			if (e < 8'd33) begin
				r.b[0] = e;
			end else if (e < 8'd67) begin
				r.b[0] = 8'd127 + (e - 8'd33);
			end else begin
				r.b[0] = 8'd173;
			end
		end else if (c < 21'h80) begin
			r.b[0] = c[7:0];
		end else if (c < 21'h800) begin
			r.n    = 3'd2;
			r.b[0] = {3'b110, c[10:6]};
			r.b[1] = {2'b10, c[5:0]};
		end else if (c < 21'h10000) begin
			r.n    = 3'd3;
			r.b[0] = {4'b1110, c[15:12]};
			r.b[1] = {2'b10, c[11:6]};
			r.b[2] = {2'b10, c[5:0]};
		end else begin
			r.n    = 3'd4;
			r.b[0] = {5'b11110, c[20:18]};
			r.b[1] = {2'b10, c[17:12]};
			r.b[2] = {2'b10, c[11:6]};
			r.b[3] = {2'b10, c[5:0]};
		end
		return r;
	endfunction

	// advance the predictor by one accepted byte, queue the decoded bytes
	task automatic predict_item(input logic [7:0] b, input logic last,
			output int unsigned produced);
		logic [7:0]  seq_b [4];
		logic [7:0]  outs [$];
		logic [20:0] c;
		cp_bytes_t   enc;
		dec_item_t   it;
		int unsigned len;
		int unsigned pos;
		int unsigned need;
		int unsigned nl;
		produced = 0;
		if (open_need < 2 || open_need > 4 || held_cnt == 0 || held_cnt >= open_need) begin
			open_need = 0;
			held_cnt  = 0;
		end
		len = 0;
		for (int unsigned k = 0; k < held_cnt && k < 3; k++) begin
			seq_b[len] = held[k];
			len++;
		end
		seq_b[len] = b;
		len++;
		need = (open_need != 0) ? open_need : lead_len(b);
		// sequence still open and string goes on: hold the byte
		if (len < need && !last) begin
			held[len - 1] = b;
			held_cnt      = len;
			open_need     = need;
			return;
		end
		if (len < need) begin
			flush_count++;
		end
		// parse what is there, a lead without its full tail stands alone
		pos = 0;
		while (pos < len) begin
			nl = lead_len(seq_b[pos]);
			if (nl > 1 && pos + nl <= len) begin
				c = {13'd0, seq_b[pos] & (8'h7F >> nl)};
				for (int unsigned i = 1; i < nl; i++) begin
					c = {c[14:0], seq_b[pos + i][5:0]};
				end
				pos += nl;
			end else begin
				c = {13'd0, seq_b[pos]};
				pos++;
			end
			enc = map_cp(c);
			for (int unsigned i = 0; i < enc.n; i++) begin
				if (outs.size() < gdec_pkg::MAX_OUT) begin
					outs = {outs, enc.b[i]};
				end
			end
		end
		held_cnt  = 0;
		open_need = 0;
		for (int unsigned i = 0; i < outs.size(); i++) begin
			it.b    = outs[i];
			it.last = last && (i == outs.size() - 1);
			exp_q   = {exp_q, it};
		end
		produced = outs.size();
		if (last) begin
			str_count++;
		end
	endtask

	// idle cycles before the next item, with stretches of none
	function automatic int unsigned draw_wait(inout int unsigned quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	// offer one byte, wait for it to be taken, then predict
	task automatic send_item(input logic [7:0] b, input logic last,
			output int unsigned produced);
		int unsigned gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = draw_wait(send_quiet);
		end
		if (gap > 0) begin
			text_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_if.valid   <= 1'b1;
		text_if.in_byte <= b;
		text_if.in_last <= last;
		do @(posedge clk); while (!text_if.ready);
		predict_item(b, last, produced);
		in_count++;
	endtask

	// continuation byte, mostly well-formed, sometimes any value
	function automatic logic [7:0] rand_cont();
		if ($urandom_range(0, 5) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	// one random group: code point sequence, noise or a cut-off sequence
	task automatic send_random_group(inout int unsigned sent);
		logic [7:0]  seq_b [4];
		int unsigned n;
		int unsigned kind;
		int unsigned produced;
		bit          ends;
		kind = $urandom_range(0, 99);
		ends = ($urandom_range(0, 7) == 0);
		if (kind < 40) begin
			n        = 1;
			seq_b[0] = 8'($urandom_range(0, 127));
		end else if (kind < 85) begin
			n = (kind < 60) ? 2 : (kind < 75) ? 3 : 4;
			case (n)
				2:       seq_b[0] = 8'($urandom_range(8'hC0, 8'hDF));
				3:       seq_b[0] = 8'($urandom_range(8'hE0, 8'hEF));
				default: seq_b[0] = 8'($urandom_range(8'hF0, 8'hF7));
			endcase
			for (int unsigned i = 1; i < n; i++) begin
				seq_b[i] = rand_cont();
			end
		end else if (kind < 93) begin
			n = $urandom_range(1, 3);
			for (int unsigned i = 0; i < n; i++) begin
				seq_b[i] = 8'($urandom_range(0, 255));
			end
		end else begin
			// lead cut short, mostly by the end of the string
			seq_b[0] = 8'($urandom_range(8'hC0, 8'hF7));
			n        = $urandom_range(1, lead_len(seq_b[0]) - 1);
			for (int unsigned i = 1; i < n; i++) begin
				seq_b[i] = rand_cont();
			end
			ends = ($urandom_range(0, 3) != 0);
		end
		for (int unsigned i = 0; i < n; i++) begin
			send_item(seq_b[i], ends && (i == n - 1), produced);
			sent++;
			// one long output stall while the input keeps coming
			if (sent == 60) begin
				hold_req   = 1'b1;
				burst_left = BURST_ITEMS;
			end
		end
	endtask

	// output side: random stalls and one long hold-off
	initial begin : recv_side
		int unsigned stall;
		dec_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_wait(recv_quiet);
			if (hold_req) begin
				stall    = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				dec_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dec_if.ready <= 1'b1;
			do @(posedge clk); while (!dec_if.valid);
		end
	end

	// compare each decoded item with the oldest expected one
	always @(posedge clk) begin : check_out
		dec_item_t want_i;
		if (arst_n && text_if.valid && !text_if.ready) begin
			stall_count++;
		end
		if (arst_n && dec_if.valid && dec_if.ready) begin
			if (exp_q.size() == 0) begin
				report_mismatch($sformatf("decoded byte %02h last %0b with none expected",
					dec_if.out_byte, dec_if.out_last));
			end else begin
				want_i = exp_q.pop_front();
				if (dec_if.out_byte !== want_i.b) begin
					report_mismatch($sformatf("item %0d out_byte %02h, want %02h",
						out_count, dec_if.out_byte, want_i.b));
				end
				if (dec_if.out_last !== want_i.last) begin
					report_mismatch($sformatf("item %0d out_last %0b, want %0b",
						out_count, dec_if.out_last, want_i.last));
				end
			end
			out_count++;
		end
	end

	// hard stop
	initial begin
		#(RUN_LIMIT);
		$display("timeout: %0d expected items still waiting", exp_q.size());
		$display("TB_ERROR");
		$finish;
	end

	// reset, directed rows, random groups, drain
	initial begin : main_seq
		int unsigned produced;
		int unsigned sent;
		text_if.valid   = 1'b0;
		text_if.in_byte = 8'h00;
		text_if.in_last = 1'b0;
		held[0]         = 8'h00;
		held[1]         = 8'h00;
		held[2]         = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int unsigned r = 0; r < 25; r++) begin
			send_item(dir_rows[r].b, dir_rows[r].last, produced);
			if (dir_rows[r].chk && (produced != 1 || exp_q[$].b != dir_rows[r].want)) begin
				report_mismatch($sformatf("row %0d predicts %0d bytes, typed %02h",
					r, produced, dir_rows[r].want));
			end
		end

		// random groups
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			send_random_group(sent);
		end
		text_if.valid <= 1'b0;

		// drain
		while (exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (exp_q.size() != 0) begin
			report_mismatch($sformatf("%0d expected items never came", exp_q.size()));
		end

		$display("run: %0d bytes in (25 directed), %0d strings ended, %0d cut-off leads",
			in_count, str_count, flush_count);
		$display("run: %0d decoded bytes checked, input held back %0d cycles, %0d mismatches",
			out_count, stall_count, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ gpt2_byte_level_utf8_decoder_core.f @@
hw/rtl/gdec_pkg.sv
hw/rtl/gdec_in_if.sv
hw/rtl/gdec_out_if.sv
hw/rtl/gdec_front.sv
hw/rtl/gdec_queue.sv
hw/rtl/gdec_back.sv
hw/rtl/gpt2_byte_level_utf8_decoder_core.sv
tb/sv/gpt2_byte_level_utf8_decoder_core_tb.sv
